// File: rtl/core/cpre_pkg.sv
// Package for the cyclic phase and rate encoder: constants, state type and helpers.
package cpre_pkg;

    localparam int PHASE_BITS_DEF = 16;

    // Q30 coefficients of the odd sine polynomial.
    localparam logic [30:0] COEF_A1 = 31'd1686629713;
    localparam logic [30:0] COEF_A3 = 31'd693598668;
    localparam logic [30:0] COEF_A5 = 31'd85569306;
    localparam logic [30:0] COEF_A7 = 31'd4858527;
    localparam logic [30:0] Q30_ONE = 31'd1073741824;

    // 128 * 10^6 * 2: the rate is (diff * RATE_SCALE + dt) / (2 * dt).
    localparam logic [30:0] RATE_SCALE = 31'd256000000;

    localparam logic [15:0] FALLBACK_RST = 16'd9472;
    localparam logic [19:0] MIN_STEP_RST = 20'd1;

    localparam logic REG_FALLBACK = 1'b0;
    localparam logic REG_MIN_STEP = 1'b1;

    localparam int NUM_W = 49;
    localparam int DSH_W = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RCHK,
        ST_RMUL,
        ST_RLOAD,
        ST_RDIV,
        ST_RFIN,
        ST_SIN,
        ST_DONE
    } state_t;

endpackage

// File: rtl/core/cpre_div.sv
// Bit-serial restoring divider that yields a 16-bit quotient, one bit per cycle.
module cpre_div
    import cpre_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [47:0]       dtv,
    output logic              done,
    output logic [15:0]       quo
);

    logic [NUM_W-1:0] num_reg, num_next;
    logic [DSH_W-1:0] dsh_reg, dsh_next;
    logic [15:0]      q_reg, q_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             ge;

    // The divisor is 2*dt aligned to the top quotient bit.
    always_comb
    begin
        num_next  = num_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        ge        = {{(DSH_W-NUM_W){1'b0}}, num_reg} >= dsh_reg;
        if (start)
        begin
            num_next  = num;
            dsh_next  = {dtv, 16'd0};
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                num_next = num_reg - dsh_reg[NUM_W-1:0];
            end
            q_next   = {q_reg[14:0], ge};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !start)
        else $error("divider restarted while busy");
    a_busy_len: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cnt_reg == 4'd15) |=> (done_reg && !busy_reg))
        else $error("divider did not finish after sixteen steps");

endmodule

// File: rtl/core/cyclic_phase_and_rate_encoder_top.sv
// Top level of the cyclic phase and rate encoder with sequencer, sine unit and APB registers.
//
//  channel | signals                          | direction | word
//  --------+----------------------------------+-----------+-------------------------------
//  in      | in_valid, in_stall, fields       | into      | one sample
//  out     | out_valid, out_stall, fields     | out of    | four phase codes and a rate
//  cfg     | psel, penable, pwrite, paddr ... | into      | fallback_temp, min_step
//
// Each word takes the four sine evaluations on the shared 31x31 multiplier; when a new rate
// is computed (not on the first sample and not when the rate is held), the bit-serial
// divider runs before them.
// Reset clears all control state and the reference; the first sample sets the reference.
// No new sample is taken while a finished word waits on a stalled output; the sequencer
// then waits in its last state until the output register frees up.
module cyclic_phase_and_rate_encoder_top
    import cpre_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        day_fraction,
    input  logic [1:0]         season_index,
    input  logic [15:0]        season_progress,
    input  logic signed [15:0] body_temp,
    input  logic               temp_present,
    input  logic [47:0]        time_stamp,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] day_sin,
    output logic signed [15:0] day_cos,
    output logic signed [15:0] year_sin,
    output logic signed [15:0] year_cos,
    output logic signed [15:0] temp_rate,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int DAY_L  = (PHASE_BITS >= 16) ? PHASE_BITS - 16 : 0;
    localparam int DAY_R  = (PHASE_BITS >= 16) ? 0 : 16 - PHASE_BITS;
    localparam int YEAR_L = (PHASE_BITS >= 18) ? PHASE_BITS - 18 : 0;
    localparam int YEAR_R = (PHASE_BITS >= 18) ? 0 : 18 - PHASE_BITS;

    state_t state_reg, state_next;

    logic signed [15:0] fallback_reg;
    logic [19:0]        min_step_reg;

    logic               have_ref_reg, have_ref_next;
    logic signed [15:0] ref_temp_reg, ref_temp_next;
    logic [47:0]        ref_time_reg, ref_time_next;
    logic signed [15:0] held_rate_reg, held_rate_next;

    logic [PHASE_BITS-1:0] day_ph_reg, year_ph_reg;
    logic signed [15:0]    cur_reg;
    logic [47:0]           now_reg;

    logic [47:0]        dt_reg, dt_next;
    logic [15:0]        mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic signed [15:0] rate_reg, rate_next;

    logic [2:0]  step_reg, step_next;
    logic [1:0]  idx_reg, idx_next;
    logic [30:0] x2_reg, x2_next;
    logic [61:0] prod_reg;
    logic [61:0] prod_next;
    logic [30:0] opa, opb;

    logic signed [15:0] res_reg [4];
    logic signed [15:0] res_val;
    logic               res_we;

    logic               out_valid_reg, out_valid_next;
    logic               out_load;
    logic signed [15:0] o_dsin_reg, o_dcos_reg, o_ysin_reg, o_ycos_reg, o_rate_reg;

    logic               div_start;
    logic               div_done;
    logic [15:0]        quo;

    logic [31:0]        angle;
    logic [1:0]         quad;
    logic [30:0]        x;
    logic [31:0]        p30;
    logic [32:0]        yr;
    logic [15:0]        smag;
    logic [48:0]        dsub;
    logic signed [16:0] diff;
    logic               accept;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign pready   = 1'b1;

    // Configuration registers; only bit 2 of the address selects a register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fallback_reg <= FALLBACK_RST;
            min_step_reg <= MIN_STEP_RST;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_FALLBACK: fallback_reg <= pwdata[15:0];
                REG_MIN_STEP: min_step_reg <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_FALLBACK: prdata = {{16{fallback_reg[15]}}, fallback_reg};
            REG_MIN_STEP: prdata = {12'd0, min_step_reg};
            default:      prdata = '0;
        endcase
    end

    // Sample capture.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            day_ph_reg  <= PHASE_BITS'(({16'd0, day_fraction} << DAY_L) >> DAY_R);
            year_ph_reg <= PHASE_BITS'(({14'd0, season_index, season_progress}
                                        << YEAR_L) >> YEAR_R);
            cur_reg     <= temp_present ? body_temp : fallback_reg;
            now_reg     <= time_stamp;
        end
    end

    // Angle of the current evaluation: sines of day and year, cosines a quarter turn on.
    always_comb
    begin
        angle = {(idx_reg[1] ? year_ph_reg : day_ph_reg), {(32-PHASE_BITS){1'b0}}};
        if (idx_reg[0])
        begin
            angle = angle + 32'h4000_0000;
        end
        quad = angle[31:30];
        x    = quad[0] ? (Q30_ONE - {1'b0, angle[29:0]}) : {1'b0, angle[29:0]};
        p30  = prod_reg[61:30];
        yr   = {1'b0, p30} + 33'd16384;
        smag = (yr[32:15] > 18'd32767) ? 16'd32767 : yr[30:15];
        res_val = quad[1] ? -$signed(smag) : $signed(smag);
    end

    // Shared multiplier operand selection; the product is registered every cycle.
    always_comb
    begin
        opa     = '0;
        opb     = '0;
        x2_next = x2_reg;
        if (state_reg == ST_SIN)
        begin
            case (step_reg)
                3'd0:
                begin
                    opa = x;
                    opb = x;
                end
                3'd1:
                begin
                    x2_next = prod_reg[60:30];
                    opa     = COEF_A7;
                    opb     = prod_reg[60:30];
                end
                3'd2:
                begin
                    opa = COEF_A5 - p30[30:0];
                    opb = x2_reg;
                end
                3'd3:
                begin
                    opa = COEF_A3 - p30[30:0];
                    opb = x2_reg;
                end
                3'd4:
                begin
                    opa = COEF_A1 - p30[30:0];
                    opb = x;
                end
                default: ;
            endcase
        end
        else if (state_reg == ST_RMUL)
        begin
            opa = {15'd0, mag_reg};
            opb = RATE_SCALE;
        end
        prod_next = {31'd0, opa} * {31'd0, opb};
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        x2_reg   <= x2_next;
        dt_reg   <= dt_next;
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        rate_reg <= rate_next;
        if (res_we)
        begin
            res_reg[idx_reg] <= res_val;
        end
    end

    assign dsub = {1'b0, now_reg} - {1'b0, ref_time_reg};
    assign diff = 17'(cur_reg) - 17'(ref_temp_reg);

    assign div_start = (state_reg == ST_RLOAD);

    cpre_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (NUM_W'(prod_reg[43:0]) + NUM_W'(dt_reg)),
        .dtv   (dt_reg),
        .done  (div_done),
        .quo   (quo)
    );

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        have_ref_next  = have_ref_reg;
        ref_temp_next  = ref_temp_reg;
        ref_time_next  = ref_time_reg;
        held_rate_next = held_rate_reg;
        dt_next        = dt_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        rate_next      = rate_reg;
        step_next      = step_reg;
        idx_next       = idx_reg;
        res_we         = 1'b0;
        out_load       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RCHK;
                end
            end
            ST_RCHK:
            begin
                dt_next   = dsub[47:0];
                neg_next  = diff[16];
                mag_next  = diff[16] ? 16'(-diff) : diff[15:0];
                rate_next = held_rate_reg;
                step_next = '0;
                idx_next  = '0;
                if (!have_ref_reg)
                begin
                    have_ref_next  = 1'b1;
                    ref_temp_next  = cur_reg;
                    ref_time_next  = now_reg;
                    held_rate_next = '0;
                    rate_next      = '0;
                    state_next     = ST_SIN;
                end
                else if (!dsub[48] && (dsub[47:0] > {28'd0, min_step_reg}))
                begin
                    state_next = ST_RMUL;
                end
                else
                begin
                    state_next = ST_SIN;
                end
            end
            ST_RMUL:
            begin
                state_next = ST_RLOAD;
            end
            ST_RLOAD:
            begin
                state_next = ST_RDIV;
            end
            ST_RDIV:
            begin
                if (div_done)
                begin
                    state_next = ST_RFIN;
                end
            end
            ST_RFIN:
            begin
                if (neg_reg)
                begin
                    rate_next = quo[15] ? 16'sh8000 : -$signed(quo);
                end
                else
                begin
                    rate_next = (quo >= 16'd32767) ? 16'sd32767 : $signed(quo);
                end
                held_rate_next = rate_next;
                ref_temp_next  = cur_reg;
                ref_time_next  = now_reg;
                state_next     = ST_SIN;
            end
            ST_SIN:
            begin
                if (step_reg == 3'd5)
                begin
                    res_we    = 1'b1;
                    step_next = '0;
                    idx_next  = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            have_ref_reg  <= 1'b0;
            ref_temp_reg  <= '0;
            ref_time_reg  <= '0;
            held_rate_reg <= '0;
            step_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            have_ref_reg  <= have_ref_next;
            ref_temp_reg  <= ref_temp_next;
            ref_time_reg  <= ref_time_next;
            held_rate_reg <= held_rate_next;
            step_reg      <= step_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            o_dsin_reg <= res_reg[0];
            o_dcos_reg <= res_reg[1];
            o_ysin_reg <= res_reg[2];
            o_ycos_reg <= res_reg[3];
            o_rate_reg <= rate_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign day_sin   = o_dsin_reg;
    assign day_cos   = o_dcos_reg;
    assign year_sin  = o_ysin_reg;
    assign year_cos  = o_ycos_reg;
    assign temp_rate = o_rate_reg;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || !out_stall))
        else $error("output word overwritten while stalled");
    a_ref_after_first: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RCHK) |=> have_ref_reg)
        else $error("reference not set after a sample");
    a_div_only_rate: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_RDIV))
        else $error("divider finished outside the rate path");
    a_rate_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RFIN) |=> (held_rate_reg == rate_reg))
        else $error("held rate differs from the new rate");

endmodule
